[hdl/mbps_pkg.sv]
package mbps_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int ADDR_W          = 48;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int LEN_CFG_W       = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 3'd0,
		REG_PAT_HIGH = 3'd1,
		REG_WILDCARD = 3'd2,
		REG_LENGTH   = 3'd3,
		REG_BASE     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID   = 2'd2
	} status_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pat_low;
		logic [CFG_DATA_W-1:0] pat_high;
		logic [PAT_BYTES-1:0]  wild;
		logic [LEN_CFG_W-1:0]  length;
	} pat_cfg_t;

endpackage

[hdl/mbps_in_if.sv]
interface mbps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/mbps_out_if.sv]
interface mbps_out_if;
	import mbps_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] hit_addr;

	modport source (output valid, output status, output hit_addr, input ready);
	modport sink (input valid, input status, input hit_addr, output ready);
endinterface

[hdl/mbps_match.sv]
module mbps_match #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
	parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
	input  logic [PATTERN_MAX-1:0][7:0] window,
	input  mbps_pkg::pat_cfg_t          cfg,
	output logic [LEN_W-1:0]            eff_len,
	output logic                        hit
);
	import mbps_pkg::*;

	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [PATTERN_MAX-1:0][7:0] pat;
	logic [PATTERN_MAX-1:0]      wild;
	logic [2*CFG_DATA_W-1:0]     pat_all;

	assign pat_all = {cfg.pat_high, cfg.pat_low};

	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			if (j < PAT_BYTES) begin
				pat[j]  = pat_all[8*j +: 8];
				wild[j] = cfg.wild[j];
			end else begin
				pat[j]  = 8'd0;
				wild[j] = 1'b0;
			end
		end
	end

	always_comb begin
		if (int'(cfg.length) > PATTERN_MAX) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end else begin
			eff_len = LEN_W'(cfg.length);
		end
	end

	always_comb begin
		int               j_int;
		logic [IDX_W-1:0] idx;
		hit   = 1'b1;
		j_int = 0;
		idx   = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (k < int'(eff_len)) begin
				j_int = int'(eff_len) - 1 - k;
				idx   = IDX_W'(j_int);
				if (!wild[idx] && window[k] != pat[idx]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

[hdl/masked_byte_pattern_scanner.sv]
// Channel | Dir | Payload                        | Accepted when
// in_ch   | in  | data_byte[7:0], last_byte      | in_ch.valid && in_ch.ready
// out_ch  | out | status[1:0], hit_addr[47:0]    | out_ch.valid && out_ch.ready
// cfg     | in  | cfg_index[2:0], cfg_data[63:0] | cfg_wr_en
//
// One word per cycle unless a stalled result holds the flow; each result is registered:
// the input register feeds the window compare and address add into the result register.
// arst_n clears valids, byte count, match flag, window and config registers.
// A stalled result holds the result register; the input register takes a word when
// empty, or when the result register is free or being drained this cycle.
module masked_byte_pattern_scanner #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
	mbps_in_if.sink                          in_ch,
	mbps_out_if.source                       out_ch
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	pat_cfg_t              cfg_q;
	logic [ADDR_W-1:0]     base_q;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;

	logic [PATTERN_MAX-1:0][7:0] win_q;
	logic [PATTERN_MAX-1:0][7:0] win_nxt;
	logic [ADDR_W-1:0]     seen_q;
	logic [ADDR_W-1:0]     seen_nxt;
	logic                  reported_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [ADDR_W-1:0]     addr_q;

	logic                  adv;
	logic                  work;
	logic                  hit;
	logic [LEN_W-1:0]      eff_len;
	logic                  found;
	logic                  res_valid;
	status_t               res_status;
	logic [ADDR_W-1:0]     res_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			base_q <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_PAT_LOW:  cfg_q.pat_low  <= cfg_data;
				REG_PAT_HIGH: cfg_q.pat_high <= cfg_data;
				REG_WILDCARD: cfg_q.wild     <= cfg_data[PAT_BYTES-1:0];
				REG_LENGTH:   cfg_q.length   <= cfg_data[LEN_CFG_W-1:0];
				REG_BASE:     base_q         <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv         = !out_valid_q || out_ch.ready;
	assign work        = valid_s1 && adv;
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
			byte_s1  <= in_ch.data_byte;
			last_s1  <= in_ch.last_byte;
		end
	end

	assign win_nxt  = {win_q[PATTERN_MAX-2:0], byte_s1};
	assign seen_nxt = (seen_q == '1) ? seen_q : seen_q + 1'b1;

	mbps_match #(
		.PATTERN_MAX (PATTERN_MAX),
		.LEN_W       (LEN_W)
	) u_match (
		.window  (win_nxt),
		.cfg     (cfg_q),
		.eff_len (eff_len),
		.hit     (hit)
	);

	assign found = !reported_q && (eff_len != '0) &&
		(seen_nxt >= ADDR_W'(eff_len)) && hit;

	always_comb begin
		res_valid  = 1'b0;
		res_status = ST_FOUND;
		res_addr   = '0;
		if (found) begin
			res_valid = 1'b1;
			res_addr  = base_q + seen_nxt - ADDR_W'(eff_len);
		end else if (last_s1 && !reported_q) begin
			res_valid  = 1'b1;
			res_status = (eff_len == '0) ? ST_INVALID : ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (work) begin
			win_q <= win_nxt;
			if (last_s1) begin
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				seen_q     <= seen_nxt;
				reported_q <= reported_q || found;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_FOUND;
			addr_q      <= '0;
		end else if (adv) begin
			out_valid_q <= work && res_valid;
			status_q    <= res_status;
			addr_q      <= res_addr;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.status   = status_q;
	assign out_ch.hit_addr = addr_q;

	a_addr_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_FOUND |-> addr_q == '0)
		else $error("match address set without a found status");

	a_region_clears: assert property (@(posedge clk) disable iff (!arst_n)
		work && last_s1 |=> seen_q == '0 && !reported_q)
		else $error("region state not cleared after last word");

	a_reported_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q |-> seen_q != '0)
		else $error("match flag set with empty byte count");

	a_invalid_needs_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_INVALID |-> cfg_q.length == '0)
		else $error("invalid status with nonzero pattern length");

endmodule
